FILE: rtl/assert_macros.svh
// Assertion macros used by greedy_box_nms.
// Expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gbn_pkg.sv
// Package for greedy_box_nms: sizes, box type and compare-unit structs.
// No dependencies.
package gbn_pkg;

  localparam int MAX_KEPT = 64;
  localparam int COORD_W  = 16;
  localparam int ID_W     = 12;
  localparam int LIM_W    = 9;
  localparam int CNT_W    = $clog2(MAX_KEPT + 1);
  localparam int IOU_LAT  = 4;
  localparam int STEP_W   = $clog2(MAX_KEPT + IOU_LAT);
  localparam int DIM_W    = COORD_W;
  localparam int AREA_W   = 2 * DIM_W;
  localparam int UNI_W    = AREA_W + 1;
  localparam int LHS_W    = AREA_W + 8;
  localparam int PROD_W   = UNI_W + LIM_W;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(128);

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
  } box_t;

  typedef struct packed {
    logic vld;
    box_t kept;
  } cmp_req_t;

  typedef struct packed {
    logic vld;
    logic pass;
  } cmp_res_t;

endpackage

FILE: rtl/gbn_cell.sv
// One storage cell of the kept-box ring: loads a new box or takes its neighbor's.
// Depends on gbn_pkg.
module gbn_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  gbn_pkg::box_t shift_in,
  input  logic          load_en,
  input  gbn_pkg::box_t load_box,
  output gbn_pkg::box_t box
);

  gbn_pkg::box_t box_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      box_r <= load_box;
    end else if (shift_en) begin
      box_r <= shift_in;
    end
  end

  assign box = box_r;

endmodule

FILE: rtl/gbn_iou.sv
// Pipelined IoU test: candidate against one kept box per cycle, four stages.
// Depends on gbn_pkg.
module gbn_iou (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gbn_pkg::box_t              cand,
  input  logic [gbn_pkg::LIM_W-1:0]  limit,
  input  gbn_pkg::cmp_req_t          req,
  output gbn_pkg::cmp_res_t          res
);

  logic signed [gbn_pkg::COORD_W-1:0] il, it, ir, ib;
  logic signed [gbn_pkg::COORD_W:0]   dx, dy;
  logic                               empty;

  logic                        vld1_r, empty1_r;
  logic [gbn_pkg::DIM_W-1:0]   iw1_r, ih1_r, cw1_r, ch1_r, kw1_r, kh1_r;
  logic                        vld2_r, empty2_r;
  logic [gbn_pkg::AREA_W-1:0]  inter2_r, aa2_r, ak2_r;
  logic                        vld3_r, empty3_r;
  logic [gbn_pkg::LHS_W-1:0]   lhs3_r;
  logic [gbn_pkg::UNI_W-1:0]   uni3_r;
  logic                        vld4_r, pass4_r;
  logic [gbn_pkg::PROD_W-1:0]  prod;

  always_comb begin
    il = (cand.l > req.kept.l) ? cand.l : req.kept.l;
    it = (cand.t > req.kept.t) ? cand.t : req.kept.t;
    ir = (cand.r < req.kept.r) ? cand.r : req.kept.r;
    ib = (cand.b < req.kept.b) ? cand.b : req.kept.b;
    dx = {ir[gbn_pkg::COORD_W-1], ir} - {il[gbn_pkg::COORD_W-1], il};
    dy = {ib[gbn_pkg::COORD_W-1], ib} - {it[gbn_pkg::COORD_W-1], it};
    empty = dx[gbn_pkg::COORD_W] || (dx == '0) || dy[gbn_pkg::COORD_W] || (dy == '0);
    prod = gbn_pkg::PROD_W'(limit) * gbn_pkg::PROD_W'(uni3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= req.vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    empty1_r <= empty;
    iw1_r    <= dx[gbn_pkg::DIM_W-1:0];
    ih1_r    <= dy[gbn_pkg::DIM_W-1:0];
    cw1_r    <= gbn_pkg::DIM_W'(cand.r - cand.l);
    ch1_r    <= gbn_pkg::DIM_W'(cand.b - cand.t);
    kw1_r    <= gbn_pkg::DIM_W'(req.kept.r - req.kept.l);
    kh1_r    <= gbn_pkg::DIM_W'(req.kept.b - req.kept.t);

    empty2_r <= empty1_r;
    inter2_r <= iw1_r * ih1_r;
    aa2_r    <= cw1_r * ch1_r;
    ak2_r    <= kw1_r * kh1_r;

    empty3_r <= empty2_r;
    lhs3_r   <= {inter2_r, 8'd0};
    uni3_r   <= gbn_pkg::UNI_W'({1'b0, aa2_r} + {1'b0, ak2_r} - {1'b0, inter2_r});

    pass4_r  <= empty3_r || (gbn_pkg::PROD_W'(lhs3_r) <= prod);
  end

  assign res.vld  = vld4_r;
  assign res.pass = pass4_r;

endmodule

FILE: rtl/greedy_box_nms.sv
// Greedy box NMS: kept boxes circulate through a ring of cells past one IoU pipeline.
// A new request is accepted only in S_IDLE, one at a time: the S_RUN state
// (MAX_KEPT ring shifts plus the 4-stage IoU drain), then S_DONE issues the result.
// While out_stall holds the result register, the block waits in S_DONE.
// Reset (sync, active low) empties the kept list and sets overlap_limit to 128.
// Depends on gbn_pkg, gbn_cell, gbn_iou and assert_macros.svh.
`include "assert_macros.svh"
module greedy_box_nms (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_first,
  input  logic [gbn_pkg::ID_W-1:0]           in_box_id,
  input  logic signed [gbn_pkg::COORD_W-1:0] in_left,
  input  logic signed [gbn_pkg::COORD_W-1:0] in_top,
  input  logic signed [gbn_pkg::COORD_W-1:0] in_right,
  input  logic signed [gbn_pkg::COORD_W-1:0] in_bottom,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gbn_pkg::ID_W-1:0]           out_result_id,
  output logic                               out_keep,
  output logic                               out_list_full,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gbn_pkg::LIM_W-1:0]          cfg_overlap_limit
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                        state_r;
  logic [gbn_pkg::CNT_W-1:0]     kept_count_r;
  logic [gbn_pkg::LIM_W-1:0]     limit_r;
  logic [gbn_pkg::STEP_W-1:0]    step_r;
  logic                          fail_r;
  gbn_pkg::box_t                 cand_r;
  logic [gbn_pkg::ID_W-1:0]      id_r;
  logic                          out_valid_r, out_keep_r, out_full_r;
  logic [gbn_pkg::ID_W-1:0]      out_id_r;

  logic                          in_acc, out_free, has_room, app_en, shift_en;
  gbn_pkg::cmp_req_t             req;
  gbn_pkg::cmp_res_t             res;
  gbn_pkg::box_t                 ring [gbn_pkg::MAX_KEPT];

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign has_room  = kept_count_r < gbn_pkg::CNT_W'(gbn_pkg::MAX_KEPT);
  assign app_en    = (state_r == S_DONE) && out_free && !fail_r && has_room;
  assign shift_en  = (state_r == S_RUN) && (step_r < gbn_pkg::STEP_W'(gbn_pkg::MAX_KEPT));

  assign req.vld  = (state_r == S_RUN) && (step_r < gbn_pkg::STEP_W'(kept_count_r));
  assign req.kept = ring[0];

  for (genvar i = 0; i < gbn_pkg::MAX_KEPT; i++) begin : g_cell
    gbn_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .shift_in (ring[(i + 1) % gbn_pkg::MAX_KEPT]),
      .load_en  (app_en && (kept_count_r == gbn_pkg::CNT_W'(i))),
      .load_box (cand_r),
      .box      (ring[i])
    );
  end

  gbn_iou u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .cand  (cand_r),
    .limit (limit_r),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kept_count_r <= '0;
      limit_r      <= gbn_pkg::LIM_RESET;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
      fail_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_overlap_limit;
      end
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cand_r <= '{l: in_left, t: in_top, r: in_right, b: in_bottom};
            id_r   <= in_box_id;
            fail_r <= 1'b0;
            step_r <= '0;
            if (in_first) begin
              kept_count_r <= '0;
            end
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          step_r <= step_r + 1'b1;
          if (res.vld && !res.pass) begin
            fail_r <= 1'b1;
          end
          if (step_r == gbn_pkg::STEP_W'(gbn_pkg::MAX_KEPT + gbn_pkg::IOU_LAT - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_id_r    <= id_r;
            out_keep_r  <= !fail_r;
            out_full_r  <= !fail_r && !has_room;
            if (app_en) begin
              kept_count_r <= kept_count_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_id = out_id_r;
  assign out_keep      = out_keep_r;
  assign out_list_full = out_full_r;

  `GBN_ASSERT_IMP(a_count_max, 1'b1, kept_count_r <= gbn_pkg::CNT_W'(gbn_pkg::MAX_KEPT), "kept count overflow")
  `GBN_ASSERT_IMP(a_full_keep, out_valid_r && out_full_r, out_keep_r, "list_full without keep")
  `GBN_ASSERT_NXT(a_acc_run, in_acc, state_r == S_RUN && step_r == '0, "accept did not start run")
  `GBN_ASSERT_IMP(a_res_run, res.vld, state_r == S_RUN, "compare result outside run")

endmodule

FILE: tb/sv/greedy_box_nms_tb.sv
// Testbench for greedy_box_nms: directed and random box sets checked against
// an in-bench greedy IoU suppression predictor. Depends on gbn_pkg and the RTL.
module greedy_box_nms_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [gbn_pkg::ID_W-1:0] id;
    logic keep;
    logic full;
  } decision_t;

  class nms_scoreboard;
    gbn_pkg::box_t kept_list[gbn_pkg::MAX_KEPT];
    int kept_n;
    logic [gbn_pkg::LIM_W-1:0] limit;
    decision_t pending[$];
    int errors;
    int checked;
    int kept_total;
    int full_total;

    function new();
      kept_n = 0;
      limit = gbn_pkg::LIM_RESET;
      errors = 0;
      checked = 0;
      kept_total = 0;
      full_total = 0;
    endfunction

    function bit survives(gbn_pkg::box_t a, gbn_pkg::box_t k);
      longint l, t, r, b, inter, aa, ak, uni;
      l = (a.l > k.l) ? longint'(a.l) : longint'(k.l);
      t = (a.t > k.t) ? longint'(a.t) : longint'(k.t);
      r = (a.r < k.r) ? longint'(a.r) : longint'(k.r);
      b = (a.b < k.b) ? longint'(a.b) : longint'(k.b);
      if (r <= l || b <= t) return 1'b1;
      inter = (r - l) * (b - t);
      aa = (longint'(a.r) - longint'(a.l)) * (longint'(a.b) - longint'(a.t));
      ak = (longint'(k.r) - longint'(k.l)) * (longint'(k.b) - longint'(k.t));
      uni = aa + ak - inter;
      return inter * 256 <= longint'(limit) * uni;
    endfunction

    function void note_request(logic first, logic [gbn_pkg::ID_W-1:0] id,
                               gbn_pkg::box_t cand);
      decision_t d;
      if (first) kept_n = 0;
      d.id = id;
      d.keep = 1'b1;
      d.full = 1'b0;
      for (int i = 0; i < kept_n; i++) begin
        if (!survives(cand, kept_list[i])) begin
          d.keep = 1'b0;
          break;
        end
      end
      if (d.keep) begin
        if (kept_n < gbn_pkg::MAX_KEPT) begin
          kept_list[kept_n] = cand;
          kept_n++;
        end else begin
          d.full = 1'b1;
        end
      end
      pending = {pending, d};
    endfunction

    function void check_result(logic [gbn_pkg::ID_W-1:0] id, logic keep, logic full);
      decision_t d;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result id=%0d", id);
        errors++;
        return;
      end
      d = pending.pop_front();
      kept_total += keep;
      full_total += full;
      if (id !== d.id) begin
        $error("result_id expected %0d actual %0d", d.id, id);
        errors++;
      end
      if (keep !== d.keep) begin
        $error("keep expected %0d actual %0d", d.keep, keep);
        errors++;
      end
      if (full !== d.full) begin
        $error("list_full expected %0d actual %0d", d.full, full);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_first = 1'b0;
  logic [gbn_pkg::ID_W-1:0] in_box_id = '0;
  logic signed [gbn_pkg::COORD_W-1:0] in_left = '0, in_top = '0, in_right = '0, in_bottom = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [gbn_pkg::ID_W-1:0] out_result_id;
  logic out_keep, out_list_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gbn_pkg::LIM_W-1:0] cfg_overlap_limit = '0;

  nms_scoreboard sb = new();
  int idle_pct = 21;
  bit hold_out = 1'b0;
  int quiet = 0;
  int sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  greedy_box_nms i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_first, .in_box_id, .in_left, .in_top,
    .in_right, .in_bottom, .out_valid, .out_stall, .out_result_id, .out_keep,
    .out_list_full, .cfg_valid, .cfg_ready, .cfg_overlap_limit
  );

  // result side: random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_result_id, out_keep, out_list_full);
    out_stall <= hold_out || ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog: no progress in %0d cycles", WATCHDOG);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_box(logic first, logic [gbn_pkg::ID_W-1:0] id, gbn_pkg::box_t bx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first <= first;
    in_box_id <= id;
    in_left <= bx.l;
    in_top <= bx.t;
    in_right <= bx.r;
    in_bottom <= bx.b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(first, id, bx);
    sent++;
  endtask

  task automatic write_limit(logic [gbn_pkg::LIM_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_overlap_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.limit = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic gbn_pkg::box_t mk(int l, int t, int r, int b);
    gbn_pkg::box_t x;
    x.l = gbn_pkg::COORD_W'(l);
    x.t = gbn_pkg::COORD_W'(t);
    x.r = gbn_pkg::COORD_W'(r);
    x.b = gbn_pkg::COORD_W'(b);
    return x;
  endfunction

  // mostly small clustered boxes so overlaps actually occur
  function automatic gbn_pkg::box_t rand_box();
    int cx, cy, w, h;
    if ($urandom_range(9) == 0)
      return mk(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                int'($signed(16'($urandom))), int'($signed(16'($urandom))));
    cx = $urandom_range(200) - 100;
    cy = $urandom_range(200) - 100;
    w = $urandom_range(60);
    h = $urandom_range(60);
    if ($urandom_range(3) == 0) begin
      cx = cx * 300;
      cy = cy * 300;
    end
    return mk(cx, cy, cx + w, cy + h);
  endfunction

  initial begin
    int set_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, degenerate, identical, threshold extremes
    send_box(1'b1, 12'd0, mk(-32768, -32768, 32767, 32767));
    send_box(1'b0, 12'hFFF, mk(-32768, -32768, 32767, 32767));
    send_box(1'b0, 12'd5, mk(10, 10, 10, 20));
    send_box(1'b0, 12'd6, mk(30, 30, 20, 20));
    send_box(1'b0, 12'd7, mk(0, 0, 10, 10));
    send_box(1'b1, 12'd8, mk(0, 0, 10, 10));
    send_box(1'b0, 12'd9, mk(0, 0, 10, 10));
    send_box(1'b0, 12'd10, mk(5, 0, 15, 10));
    send_box(1'b0, 12'd11, mk(10, 0, 20, 10));
    write_limit(9'd0);
    send_box(1'b1, 12'd12, mk(0, 0, 10, 10));
    send_box(1'b0, 12'd13, mk(9, 9, 20, 20));
    send_box(1'b0, 12'd14, mk(10, 10, 20, 20));
    write_limit(9'd511);
    send_box(1'b1, 12'd15, mk(0, 0, 10, 10));
    send_box(1'b0, 12'd16, mk(0, 0, 10, 10));
    write_limit(9'd256);
    send_box(1'b0, 12'd17, mk(0, 0, 10, 10));
    // full list: 66 disjoint boxes
    write_limit(gbn_pkg::LIM_RESET);
    for (int i = 0; i < 66; i++)
      send_box(i == 0, 12'(100 + i), mk(i * 20, 0, i * 20 + 10, 10));
    // pressure: hold receiver while sender keeps offering
    hold_out = 1'b1;
    fork
      begin
        for (int i = 0; i < 4; i++) send_box(1'b0, 12'(200 + i), rand_box());
      end
      begin
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
    join
    // random phases over several thresholds, one with no idle gaps or stalls
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_limit(9'd128);
        1: write_limit(9'd0);
        2: write_limit(9'd256);
        3: write_limit(9'd300);
        default: write_limit(9'($urandom_range(256)));
      endcase
      idle_pct = (ph == 2) ? 0 : 21;
      for (int n = 0; n < 145; n++) begin
        set_len = (n == 0) || ($urandom_range(29) == 0);
        send_box(set_len[0], 12'($urandom), rand_box());
      end
    end
    in_valid <= 1'b0;
    idle_pct = 21;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d boxes sent, %0d decisions checked (%0d kept, %0d list full)",
             sent, sb.checked, sb.kept_total, sb.full_total);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
